[rtl/core/i2cbm_pkg.sv]
package i2cbm_pkg;

    // Number of data bits in one bus byte.
    localparam int BITS_PER_BYTE = 8;

    localparam int DATA_W = 8;
    localparam int CNT_W  = 4;
    localparam int KIND_W = 3;

    // Reset value of the acknowledge timeout register.
    localparam logic [DATA_W-1:0] ACK_TIMEOUT_RST = 8'd250;

    // Command codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    // Register index on the configuration port.
    localparam logic REG_ACK_TIMEOUT = 1'b0;

    typedef enum logic [20:0] {
        PH_IDLE = 21'h000001,
        PH_ST_A = 21'h000002,
        PH_ST_B = 21'h000004,
        PH_ST_C = 21'h000008,
        PH_SP_A = 21'h000010,
        PH_SP_B = 21'h000020,
        PH_SP_C = 21'h000040,
        PH_WR_D = 21'h000080,
        PH_WR_C = 21'h000100,
        PH_WR_R = 21'h000200,
        PH_WA_C = 21'h000400,
        PH_WA_P = 21'h000800,
        PH_AB_B = 21'h001000,
        PH_AB_C = 21'h002000,
        PH_WA_E = 21'h004000,
        PH_RD_C = 21'h008000,
        PH_RD_L = 21'h010000,
        PH_RA_A = 21'h020000,
        PH_RA_B = 21'h040000,
        PH_RA_C = 21'h080000,
        PH_RA_D = 21'h100000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] wr_data;
        logic              send_ack;
        logic              sda_in;
    } item_t;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] rx_data;
        logic              ack_error;
        logic              cmd_rejected;
    } result_t;

endpackage

[rtl/core/i2cbm_regs.sv]
module i2cbm_regs
    import i2cbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [DATA_W-1:0]     ack_timeout
);

    logic [DATA_W-1:0] ack_timeout_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ACK_TIMEOUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            ack_timeout_reg <= pwdata[DATA_W-1:0];
        end
    end

    // Addresses beyond the single register read as zero.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ACK_TIMEOUT)
        begin
            prdata = {{(32-DATA_W){1'b0}}, ack_timeout_reg};
        end
    end

    assign ack_timeout = ack_timeout_reg;

endmodule

[rtl/core/i2cbm_engine.sv]
module i2cbm_engine
    import i2cbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  item_t             item,
    input  logic [DATA_W-1:0] ack_timeout,
    output result_t           res
);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [DATA_W-1:0] shift_reg, shift_next;
    logic [DATA_W-1:0] wait_count_reg, wait_count_next;
    logic              ack_flag_reg, ack_flag_next;
    logic              ack_mode_reg, ack_mode_next;
    logic              scl_level_reg, scl_level_next;
    logic              sda_level_reg, sda_level_next;
    logic [DATA_W-1:0] rx_hold_reg, rx_hold_next;

    logic              is_cmd;
    logic              idle;
    logic              fin;
    logic [CNT_W-1:0]  bc_inc;
    logic [DATA_W:0]   wait_inc;

    assign is_cmd = (item.kind == KIND_START) || (item.kind == KIND_STOP) ||
                    (item.kind == KIND_WRITE) || (item.kind == KIND_READ);
    assign idle   = (phase_reg == PH_IDLE);

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        wait_count_next = wait_count_reg;
        ack_flag_next   = ack_flag_reg;
        ack_mode_next   = ack_mode_reg;
        scl_level_next  = scl_level_reg;
        sda_level_next  = sda_level_reg;
        rx_hold_next    = rx_hold_reg;
        fin             = 1'b0;

        // A command taken while idle sets up its sequence; the first line
        // action then runs on the same tick.
        if (idle && is_cmd)
        begin
            bit_count_next = '0;
            case (item.kind)
                KIND_START: phase_next = PH_ST_A;
                KIND_STOP:  phase_next = PH_SP_A;
                KIND_WRITE:
                begin
                    shift_next    = item.wr_data;
                    ack_flag_next = 1'b0;
                    phase_next    = PH_WR_D;
                end
                default:
                begin
                    shift_next    = '0;
                    ack_mode_next = item.send_ack;
                    phase_next    = PH_RD_C;
                end
            endcase
        end

        bc_inc   = bit_count_next + 1'b1;
        wait_inc = {1'b0, wait_count_next} + 1'b1;

        case (phase_next)
            PH_IDLE: ;
            PH_ST_A:
            begin
                sda_level_next = 1'b1;
                scl_level_next = 1'b1;
                phase_next     = PH_ST_B;
            end
            PH_ST_B:
            begin
                sda_level_next = 1'b0;
                phase_next     = PH_ST_C;
            end
            PH_ST_C:
            begin
                scl_level_next = 1'b0;
                fin            = 1'b1;
            end
            PH_SP_A:
            begin
                sda_level_next = 1'b0;
                phase_next     = PH_SP_B;
            end
            PH_SP_B:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_SP_C;
            end
            PH_SP_C:
            begin
                sda_level_next = 1'b1;
                fin            = 1'b1;
            end
            PH_WR_D:
            begin
                scl_level_next = 1'b0;
                sda_level_next = shift_next[DATA_W-1];
                phase_next     = PH_WR_C;
            end
            PH_WR_C:
            begin
                scl_level_next = 1'b1;
                shift_next     = {shift_next[DATA_W-2:0], 1'b0};
                bit_count_next = bc_inc;
                phase_next     = (bc_inc >= CNT_W'(BITS_PER_BYTE)) ? PH_WR_R : PH_WR_D;
            end
            PH_WR_R:
            begin
                scl_level_next  = 1'b0;
                sda_level_next  = 1'b1;
                wait_count_next = '0;
                phase_next      = PH_WA_C;
            end
            PH_WA_C:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_WA_P;
            end
            PH_WA_P:
            begin
                if (!item.sda_in)
                begin
                    scl_level_next = 1'b0;
                    fin            = 1'b1;
                end
                else if (wait_inc > {1'b0, ack_timeout})
                begin
                    ack_flag_next  = 1'b1;
                    sda_level_next = 1'b0;
                    phase_next     = PH_AB_B;
                end
                else
                begin
                    wait_count_next = wait_inc[DATA_W-1:0];
                end
            end
            PH_AB_B:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_AB_C;
            end
            PH_AB_C:
            begin
                sda_level_next = 1'b1;
                phase_next     = PH_WA_E;
            end
            PH_WA_E:
            begin
                scl_level_next = 1'b0;
                fin            = 1'b1;
            end
            PH_RD_C:
            begin
                sda_level_next = 1'b1;
                scl_level_next = 1'b1;
                shift_next     = {shift_next[DATA_W-2:0], item.sda_in};
                bit_count_next = bc_inc;
                phase_next     = PH_RD_L;
            end
            PH_RD_L:
            begin
                scl_level_next = 1'b0;
                if (bit_count_next >= CNT_W'(BITS_PER_BYTE))
                begin
                    rx_hold_next = shift_next;
                    phase_next   = PH_RA_A;
                end
                else
                begin
                    phase_next = PH_RD_C;
                end
            end
            PH_RA_A:
            begin
                sda_level_next = !ack_mode_next;
                phase_next     = PH_RA_B;
            end
            PH_RA_B:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_RA_C;
            end
            PH_RA_C:
            begin
                scl_level_next = 1'b0;
                if (ack_mode_next)
                begin
                    phase_next = PH_RA_D;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            PH_RA_D:
            begin
                sda_level_next = 1'b1;
                fin            = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase

        if (fin)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            wait_count_reg <= '0;
            ack_flag_reg   <= 1'b0;
            ack_mode_reg   <= 1'b0;
            scl_level_reg  <= 1'b1;
            sda_level_reg  <= 1'b1;
            rx_hold_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            wait_count_reg <= wait_count_next;
            ack_flag_reg   <= ack_flag_next;
            ack_mode_reg   <= ack_mode_next;
            scl_level_reg  <= scl_level_next;
            sda_level_reg  <= sda_level_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

    always_comb
    begin
        res.scl_out      = scl_level_next;
        res.sda_out      = sda_level_next;
        res.busy_res     = (phase_next != PH_IDLE);
        res.done_res     = fin;
        res.rx_data      = rx_hold_next;
        res.ack_error    = ack_flag_next;
        res.cmd_rejected = !idle && is_cmd;
    end

endmodule

[rtl/core/i2c_bit_level_master.sv]
// Channel  Direction  Handshake          Payload
// input    in         in_valid/in_stall  kind, wr_data, send_ack, sda_in
// output   out        out_valid/out_stall scl_out, sda_out, busy_res, done_res,
//                                         rx_data, ack_error, cmd_rejected
// config   APB        psel/penable/pready ack_timeout at byte address 0
//
// Every input word is one bus half-period tick and yields exactly one result word.
// The block takes one word per cycle unless the output stalls. A word in the input
// register goes through the phase logic into the result register once the result
// register is free, and its result is then offered on the output.
// Reset is asynchronous and active low; it returns the sequencer's line levels to
// released and the timeout to 250. A stall on the output holds the result register;
// while the input register also holds a word, in_stall is high in that same cycle.
module i2c_bit_level_master
    import i2cbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              send_ack,
    input  logic              sda_in,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              scl_out,
    output logic              sda_out,
    output logic              busy_res,
    output logic              done_res,
    output logic [DATA_W-1:0] rx_data,
    output logic              ack_error,
    output logic              cmd_rejected,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic              in_valid_reg;
    item_t             in_item_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    result_t           res;
    logic [DATA_W-1:0] ack_timeout;
    logic              out_free;
    logic              step;
    logic              in_take;

    // The result register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    // The input word goes through the phase logic when the result slot is free.
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    i2cbm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .ack_timeout (ack_timeout)
    );

    i2cbm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .ack_timeout (ack_timeout),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.kind     <= kind;
            in_item_reg.wr_data  <= wr_data;
            in_item_reg.send_ack <= send_ack;
            in_item_reg.sda_in   <= sda_in;
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_out      = out_res_reg.scl_out;
    assign sda_out      = out_res_reg.sda_out;
    assign busy_res     = out_res_reg.busy_res;
    assign done_res     = out_res_reg.done_res;
    assign rx_data      = out_res_reg.rx_data;
    assign ack_error    = out_res_reg.ack_error;
    assign cmd_rejected = out_res_reg.cmd_rejected;

endmodule

[tb/sv/i2c_bit_level_master_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the tick-driven I2C master. Every word sent in is one
// bus half-period tick and produces exactly one result word. A behavioral copy of
// the phase sequencer below runs in step with the accepted input words and queues
// the result each one should produce. The output monitor pops that queue for every
// accepted result word and compares it field by field.
module i2c_bit_level_master_test;
    import i2cbm_pkg::*;

    // Kinds above the read command carry no meaning and act as a plain tick.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // A word passes the input register and then the result register. The drain
    // margin covers a sequencer that is still moving when the last result is out.
    localparam int LATENCY      = 2;
    localparam int DRAIN_CYCLES = LATENCY + 4;

    // Longest quiet stretch in a correct run is a sender gap overlapping a
    // receiver stall plus a register write, far below the watchdog limit.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int MAX_WAIT          = 17;
    localparam int WORDS_PER_SETTING = 300;
    localparam int SETTING_COUNT     = 6;

    localparam logic [2:0] TIMEOUT_ADDR = 3'(4 * int'(REG_ACK_TIMEOUT));

    localparam result_t UNCHECKED = '0;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] wr_data;
    logic              send_ack;
    logic              sda_in;
    logic              out_valid;
    logic              out_stall;
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] rx_data;
    logic              ack_error;
    logic              cmd_rejected;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    i2c_bit_level_master dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .wr_data      (wr_data),
        .send_ack     (send_ack),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_data      (rx_data),
        .ack_error    (ack_error),
        .cmd_rejected (cmd_rejected),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow copy of the sequencer state and of the timeout register.
    phase_t            bus_phase;
    logic [CNT_W-1:0]  bits_done;
    logic [DATA_W-1:0] shifter;
    logic [DATA_W-1:0] poll_count;
    logic              nack_seen;
    logic              ack_reply;
    logic              scl_lvl;
    logic              sda_lvl;
    logic [DATA_W-1:0] rx_last;
    logic [DATA_W-1:0] timeout_reg;

    result_t bus_results_due[$];
    result_t got_word;
    result_t want_word;
    int      error_count;
    int      results_seen;
    int      quiet_cycles;
    int      ack_low_pct;
    logic    steady_in;
    logic    steady_out;

    // One line of the directed script. A line either writes the timeout register
    // or sends the same word a number of times in a row. Where the outcome is
    // obvious it is typed in; otherwise the shadow sequencer supplies it.
    typedef struct {
        logic              set_cfg;
        logic [DATA_W-1:0] cfg_value;
        logic [KIND_W-1:0] w_kind;
        logic [DATA_W-1:0] w_data;
        logic              w_ack;
        logic              w_sda;
        int                reps;
        logic              typed;
        result_t           want;
    } stim_row_t;

    stim_row_t script [26] = '{
        // Idle tick straight after reset: both lines released, nothing going on.
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 1, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
        // Start condition: first tick raises both lines and stays busy.
        '{1'b0, 8'd0, KIND_START, 8'h00, 1'b0, 1'b1, 1, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
        // A write arriving mid-start is dropped and flagged; SDA falls.
        '{1'b0, 8'd0, KIND_WRITE, 8'hFF, 1'b0, 1'b1, 1, 1'b1,
          '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
        // SCL drops and the start completes.
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0}},
        // Zero timeout: the first high sample of the acknowledge aborts the write.
        '{1'b1, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b0, 0, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_WRITE, 8'hFF, 1'b0, 1'b1, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 21, 1'b0, UNCHECKED},
        // Read all ones with NACK; the error flag from the write must hold.
        '{1'b0, 8'd0, KIND_READ, 8'h00, 1'b0, 1'b1, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 20, 1'b0, UNCHECKED},
        // Largest timeout, then a stop so the next write starts from a released SCL.
        '{1'b1, 8'd255, KIND_TICK, 8'h00, 1'b0, 1'b0, 0, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_STOP, 8'h00, 1'b0, 1'b1, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 3, 1'b0, UNCHECKED},
        // Write all zeros, acknowledged at once; this clears the error flag.
        '{1'b0, 8'd0, KIND_WRITE, 8'h00, 1'b0, 1'b0, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b0, 19, 1'b0, UNCHECKED},
        // Read all zeros with ACK, which adds the SDA release tick at the end.
        '{1'b0, 8'd0, KIND_READ, 8'h00, 1'b1, 1'b0, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b0, 21, 1'b0, UNCHECKED},
        // Meaningless kinds, first while idle and then in the middle of a start.
        '{1'b0, 8'd0, KIND_SPARE_HI, 8'h00, 1'b0, 1'b1, 2, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_START, 8'h00, 1'b0, 1'b1, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_SPARE_LO, 8'h00, 1'b0, 1'b1, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 2, 1'b0, UNCHECKED},
        // Long acknowledge poll with SDA left high.
        '{1'b0, 8'd0, KIND_WRITE, 8'hA5, 1'b0, 1'b1, 1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 40, 1'b0, UNCHECKED},
        // A stop during the poll is rejected; the poll carries on unchanged.
        '{1'b0, 8'd0, KIND_STOP, 8'h00, 1'b0, 1'b1, 1, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{1'b0, 8'd0, KIND_READ, 8'h00, 1'b1, 1'b1, 1, 1'b0, UNCHECKED},
        // Timeout lowered while the poll is still running: the next high sample
        // is already past it, so the write aborts with a stop.
        '{1'b1, 8'd1, KIND_TICK, 8'h00, 1'b0, 1'b0, 0, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, KIND_TICK, 8'h00, 1'b0, 1'b1, 6, 1'b0, UNCHECKED}
    };

    task automatic report(input string msg);
        $display("%0t ERROR %s", $time, msg);
        error_count++;
    endtask

    function automatic void reset_shadow();
        bus_phase   = PH_IDLE;
        bits_done   = '0;
        shifter     = '0;
        poll_count  = '0;
        nack_seen   = 1'b0;
        ack_reply   = 1'b0;
        scl_lvl     = 1'b1;
        sda_lvl     = 1'b1;
        rx_last     = '0;
        timeout_reg = ACK_TIMEOUT_RST;
    endfunction

    // Carries out the line action of the current phase. Returns 1 on the tick
    // that finishes a command sequence.
    function automatic logic step_phase(input logic sda);
        logic fin;
        fin = 1'b0;
        case (bus_phase)
            PH_ST_A:
            begin
                sda_lvl   = 1'b1;
                scl_lvl   = 1'b1;
                bus_phase = PH_ST_B;
            end
            PH_ST_B:
            begin
                sda_lvl   = 1'b0;
                bus_phase = PH_ST_C;
            end
            PH_ST_C:
            begin
                scl_lvl = 1'b0;
                fin     = 1'b1;
            end
            PH_SP_A:
            begin
                sda_lvl   = 1'b0;
                bus_phase = PH_SP_B;
            end
            PH_SP_B:
            begin
                scl_lvl   = 1'b1;
                bus_phase = PH_SP_C;
            end
            PH_SP_C:
            begin
                sda_lvl = 1'b1;
                fin     = 1'b1;
            end
            PH_WR_D:
            begin
                scl_lvl   = 1'b0;
                sda_lvl   = shifter[DATA_W-1];
                bus_phase = PH_WR_C;
            end
            PH_WR_C:
            begin
                scl_lvl   = 1'b1;
                shifter   = shifter << 1;
                bits_done = bits_done + 1'b1;
                bus_phase = (bits_done >= BITS_PER_BYTE) ? PH_WR_R : PH_WR_D;
            end
            PH_WR_R:
            begin
                scl_lvl    = 1'b0;
                sda_lvl    = 1'b1;
                poll_count = '0;
                bus_phase  = PH_WA_C;
            end
            PH_WA_C:
            begin
                scl_lvl   = 1'b1;
                bus_phase = PH_WA_P;
            end
            PH_WA_P:
            begin
                if (!sda)
                begin
                    scl_lvl = 1'b0;
                    fin     = 1'b1;
                end
                else if (int'(poll_count) + 1 > int'(timeout_reg))
                begin
                    nack_seen = 1'b1;
                    sda_lvl   = 1'b0;
                    bus_phase = PH_AB_B;
                end
                else
                begin
                    poll_count = poll_count + 1'b1;
                end
            end
            PH_AB_B:
            begin
                scl_lvl   = 1'b1;
                bus_phase = PH_AB_C;
            end
            PH_AB_C:
            begin
                sda_lvl   = 1'b1;
                bus_phase = PH_WA_E;
            end
            PH_WA_E:
            begin
                scl_lvl = 1'b0;
                fin     = 1'b1;
            end
            PH_RD_C:
            begin
                sda_lvl   = 1'b1;
                scl_lvl   = 1'b1;
                shifter   = {shifter[DATA_W-2:0], sda};
                bits_done = bits_done + 1'b1;
                bus_phase = PH_RD_L;
            end
            PH_RD_L:
            begin
                scl_lvl = 1'b0;
                if (bits_done >= BITS_PER_BYTE)
                begin
                    rx_last   = shifter;
                    bus_phase = PH_RA_A;
                end
                else
                begin
                    bus_phase = PH_RD_C;
                end
            end
            PH_RA_A:
            begin
                sda_lvl   = !ack_reply;
                bus_phase = PH_RA_B;
            end
            PH_RA_B:
            begin
                scl_lvl   = 1'b1;
                bus_phase = PH_RA_C;
            end
            PH_RA_C:
            begin
                scl_lvl = 1'b0;
                if (ack_reply)
                    bus_phase = PH_RA_D;
                else
                    fin = 1'b1;
            end
            PH_RA_D:
            begin
                sda_lvl = 1'b1;
                fin     = 1'b1;
            end
            default:
            begin
                bus_phase = PH_IDLE;
            end
        endcase
        if (fin)
            bus_phase = PH_IDLE;
        return fin;
    endfunction

    // Advances the shadow sequencer by one tick and returns the result word that
    // this tick should produce. A command is only taken up while idle, and its
    // first line action happens on the same tick.
    function automatic result_t predict_tick(input logic [KIND_W-1:0] w_kind,
                                             input logic [DATA_W-1:0] w_data,
                                             input logic w_ack, input logic w_sda);
        result_t r;
        logic    is_cmd;
        logic    fin;
        logic    rejected;
        is_cmd   = (w_kind >= KIND_START) && (w_kind <= KIND_READ);
        fin      = 1'b0;
        rejected = 1'b0;
        if (bus_phase == PH_IDLE)
        begin
            if (is_cmd)
            begin
                bits_done = '0;
                case (w_kind)
                    KIND_START: bus_phase = PH_ST_A;
                    KIND_STOP:  bus_phase = PH_SP_A;
                    KIND_WRITE:
                    begin
                        shifter   = w_data;
                        nack_seen = 1'b0;
                        bus_phase = PH_WR_D;
                    end
                    default:
                    begin
                        shifter   = '0;
                        ack_reply = w_ack;
                        bus_phase = PH_RD_C;
                    end
                endcase
                fin = step_phase(w_sda);
            end
        end
        else
        begin
            rejected = is_cmd;
            fin      = step_phase(w_sda);
        end
        r.scl_out      = scl_lvl;
        r.sda_out      = sda_lvl;
        r.busy_res     = (bus_phase != PH_IDLE);
        r.done_res     = fin;
        r.rx_data      = rx_last;
        r.ack_error    = nack_seen;
        r.cmd_rejected = rejected;
        return r;
    endfunction

    // Sends one word after a random gap and holds it until the block takes it.
    // The valid line is left high on return so that a back-to-back word needs no
    // second assignment at the same edge; rest_input lowers it when needed.
    task automatic drive_word(input logic [KIND_W-1:0] w_kind,
                              input logic [DATA_W-1:0] w_data,
                              input logic w_ack, input logic w_sda,
                              input logic typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = steady_in ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= w_kind;
        wr_data  <= w_data;
        send_ack <= w_ack;
        sda_in   <= w_sda;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = predict_tick(w_kind, w_data, w_ack, w_sda);
        bus_results_due.push_back(typed ? want : predicted);
        if ($urandom_range(0, 31) == 0)
            steady_in = !steady_in;
    endtask

    task automatic rest_input();
        in_valid <= 1'b0;
    endtask

    // Register writes happen only with the pipeline empty. The sequencer itself
    // may still be in the middle of a bus command, which the block allows.
    task automatic write_timeout(input logic [DATA_W-1:0] value);
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        timeout_reg = value;
        // Read the register straight back on the same port.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[DATA_W-1:0] !== timeout_reg)
            report($sformatf("timeout readback %0d, written %0d",
                             prdata[DATA_W-1:0], timeout_reg));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Chooses the next random word from where the shadow sequencer stands. When
    // idle it mostly issues well-formed commands; when busy it mostly ticks, with
    // the odd rejected command or meaningless kind thrown in. Each write draws how
    // eager the target is to acknowledge, so that both the quick acknowledge and
    // the timeout abort turn up under every timeout setting.
    task automatic pick_word(output logic [KIND_W-1:0] w_kind,
                             output logic [DATA_W-1:0] w_data,
                             output logic w_ack, output logic w_sda);
        int roll;
        roll   = $urandom_range(0, 99);
        w_data = DATA_W'($urandom);
        w_ack  = 1'($urandom);
        w_sda  = 1'($urandom);
        if (bus_phase == PH_IDLE)
        begin
            if (roll < 8)
                w_kind = KIND_TICK;
            else if (roll < 12)
                w_kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else if (roll < 30)
                w_kind = KIND_START;
            else if (roll < 45)
                w_kind = KIND_STOP;
            else if (roll < 75)
            begin
                w_kind = KIND_WRITE;
                case ($urandom_range(0, 3))
                    0:       ack_low_pct = 0;
                    1:       ack_low_pct = 5;
                    2:       ack_low_pct = 30;
                    default: ack_low_pct = 90;
                endcase
            end
            else
                w_kind = KIND_READ;
        end
        else
        begin
            if (roll < 4)
                w_kind = KIND_W'($urandom_range(KIND_START, KIND_READ));
            else if (roll < 6)
                w_kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else
                w_kind = KIND_TICK;
            if (bus_phase == PH_WA_P)
                w_sda = ($urandom_range(0, 99) < ack_low_pct) ? 1'b0 : 1'b1;
        end
    endtask

    task automatic compare_word(input result_t got, input result_t want);
        if (got.scl_out !== want.scl_out)
            report($sformatf("word %0d scl_out %b, want %b",
                             results_seen, got.scl_out, want.scl_out));
        if (got.sda_out !== want.sda_out)
            report($sformatf("word %0d sda_out %b, want %b",
                             results_seen, got.sda_out, want.sda_out));
        if (got.busy_res !== want.busy_res)
            report($sformatf("word %0d busy_res %b, want %b",
                             results_seen, got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
            report($sformatf("word %0d done_res %b, want %b",
                             results_seen, got.done_res, want.done_res));
        if (got.rx_data !== want.rx_data)
            report($sformatf("word %0d rx_data %02h, want %02h",
                             results_seen, got.rx_data, want.rx_data));
        if (got.ack_error !== want.ack_error)
            report($sformatf("word %0d ack_error %b, want %b",
                             results_seen, got.ack_error, want.ack_error));
        if (got.cmd_rejected !== want.cmd_rejected)
            report($sformatf("word %0d cmd_rejected %b, want %b",
                             results_seen, got.cmd_rejected, want.cmd_rejected));
    endtask

    // Output monitor. Values are read at the rising edge, before the block's own
    // updates for that edge land, so they are the ones the handshake acted on.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got_word = '{scl_out, sda_out, busy_res, done_res, rx_data,
                         ack_error, cmd_rejected};
            if (bus_results_due.size() == 0)
                report($sformatf("word %0d arrived with nothing expected", results_seen));
            else
            begin
                want_word = bus_results_due.pop_front();
                compare_word(got_word, want_word);
            end
            results_seen++;
        end
    end

    // Receiver: for every result word it draws a number of cycles to hold off
    // before it lets the next one through. Now and then it switches into a steady
    // stretch where it never stalls at all.
    initial
    begin
        int hold;
        out_stall  <= 1'b0;
        steady_out = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = steady_out ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if ($urandom_range(0, 31) == 0)
                steady_out = !steady_out;
        end
    end

    // The watchdog restarts whenever a word moves on either side or a register
    // access is under way. A run that goes quiet for too long has hung.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0) || psel === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no progress for %0d cycles", $time, quiet_cycles);
            $display("i2c_bit_level_master_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int                timeout_plan [SETTING_COUNT];
        logic [KIND_W-1:0] r_kind;
        logic [DATA_W-1:0] r_data;
        logic              r_ack;
        logic              r_sda;

        error_count  = 0;
        results_seen = 0;
        quiet_cycles = 0;
        ack_low_pct  = 50;
        steady_in    = 1'b0;
        reset_shadow();

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        kind     <= KIND_TICK;
        wr_data  <= '0;
        send_ack <= 1'b0;
        sda_in   <= 1'b1;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script: reset state, every command, the bus extremes, and the
        // timeout corner cases.
        foreach (script[i])
        begin
            if (script[i].set_cfg)
            begin
                rest_input();
                write_timeout(script[i].cfg_value);
            end
            else
            begin
                repeat (script[i].reps)
                    drive_word(script[i].w_kind, script[i].w_data, script[i].w_ack,
                               script[i].w_sda, script[i].typed, script[i].want);
            end
        end

        // Random traffic under several timeout settings: the smallest nonzero value,
        // the largest, short ones that abort often, the reset value and one at
        // random anywhere in range.
        timeout_plan[0] = 1;
        timeout_plan[1] = 255;
        timeout_plan[2] = $urandom_range(2, 6);
        timeout_plan[3] = $urandom_range(7, 40);
        timeout_plan[4] = int'(ACK_TIMEOUT_RST);
        timeout_plan[5] = $urandom_range(1, 255);
        foreach (timeout_plan[p])
        begin
            rest_input();
            write_timeout(DATA_W'(timeout_plan[p]));
            repeat (WORDS_PER_SETTING)
            begin
                pick_word(r_kind, r_data, r_ack, r_sda);
                drive_word(r_kind, r_data, r_ack, r_sda, 1'b0, UNCHECKED);
            end
        end

        rest_input();
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("i2c_bit_level_master_test: done, clean");
        else
            $display("i2c_bit_level_master_test: done, errors");
        $finish;
    end

endmodule
